/* design/gasf_pkg.sv */
// gasf_pkg: shared types and constants for the global alignment score fill
// used by gasf_ctrl, gasf_cell and global_alignment_score_fill
package gasf_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_SCORE_BITS  = 32;

  localparam int SYM_W       = 8;
  localparam int ROW_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_SCORE_W = 32;

  localparam logic [ROW_W-1:0] ROW_LIMIT = 16'hFFFF;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ROW  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

  localparam logic signed [CFG_DATA_W-1:0] RESET_MATCH    = 8'sd5;
  localparam logic signed [CFG_DATA_W-1:0] RESET_MISMATCH = -8'sd4;
  localparam logic signed [CFG_DATA_W-1:0] RESET_GAP      = -8'sd5;

  typedef struct packed {
    logic signed [CFG_DATA_W-1:0] match_score;
    logic signed [CFG_DATA_W-1:0] mismatch_score;
    logic signed [CFG_DATA_W-1:0] gap_score;
  } score_cfg_t;

  typedef struct packed {
    logic             first_row;
    logic [SYM_W-1:0] sym;
    logic [ROW_W-1:0] row;
    logic             is_final;
  } tag_t;

endpackage

/* design/gasf_cell.sv */
// gasf_cell: one column of the systolic score row, holds symbol and upper score
// depends on gasf_pkg
module gasf_cell #(
  parameter int SCORE_BITS = gasf_pkg::DEF_SCORE_BITS,
  parameter int COL_IDX    = 0,
  parameter int IDX_W      = 10,
  parameter int CNT_W      = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gasf_pkg::score_cfg_t           cfg,
  input  logic [CNT_W-1:0]               col_count,
  input  logic                           load_we,
  input  logic [IDX_W-1:0]               load_idx,
  input  logic [gasf_pkg::SYM_W-1:0]     load_sym,
  input  logic                           in_valid,
  input  gasf_pkg::tag_t                 in_tag,
  input  logic signed [SCORE_BITS-1:0]   in_left,
  input  logic signed [SCORE_BITS-1:0]   in_diag,
  input  logic signed [SCORE_BITS-1:0]   in_top,
  output logic                           out_valid_r,
  output gasf_pkg::tag_t                 out_tag_r,
  output logic signed [SCORE_BITS-1:0]   out_left_r,
  output logic signed [SCORE_BITS-1:0]   out_diag_r,
  output logic signed [SCORE_BITS-1:0]   out_top_r
);
  import gasf_pkg::*;

  localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  function automatic logic signed [SCORE_BITS-1:0] sat_w(input logic signed [SCORE_BITS:0] v);
    logic signed [SCORE_BITS:0] hi_e;
    logic signed [SCORE_BITS:0] lo_e;
    hi_e = (SCORE_BITS+1)'(SMAX);
    lo_e = (SCORE_BITS+1)'(SMIN);
    if (v > hi_e) begin
      return SMAX;
    end else if (v < lo_e) begin
      return SMIN;
    end else begin
      return v[SCORE_BITS-1:0];
    end
  endfunction

  logic [SYM_W-1:0]              sym_r;
  logic signed [SCORE_BITS-1:0]  prev_r;
  logic                          active;
  logic signed [SCORE_BITS-1:0]  up;
  logic signed [CFG_DATA_W-1:0]  ms_sel;
  logic signed [SCORE_BITS:0]    s_up;
  logic signed [SCORE_BITS:0]    s_left;
  logic signed [SCORE_BITS:0]    s_diag;
  logic signed [SCORE_BITS:0]    s_best;
  logic signed [SCORE_BITS:0]    s_top;
  logic signed [SCORE_BITS-1:0]  best;

  assign active = CNT_W'(COL_IDX) < col_count;
  assign up     = in_tag.first_row ? in_top : prev_r;
  assign ms_sel = (sym_r == in_tag.sym) ? cfg.match_score : cfg.mismatch_score;
  assign s_up   = up + cfg.gap_score;
  assign s_left = in_left + cfg.gap_score;
  assign s_diag = in_diag + ms_sel;
  assign s_top  = in_top + cfg.gap_score;

  always_comb begin
    s_best = s_up;
    if (s_left > s_best) begin
      s_best = s_left;
    end
    if (s_diag > s_best) begin
      s_best = s_diag;
    end
  end

  assign best = sat_w(s_best);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r <= in_tag;
    out_top_r <= sat_w(s_top);
    if (active) begin
      out_left_r <= best;
      out_diag_r <= up;
    end else begin
      out_left_r <= in_left;
      out_diag_r <= in_diag;
    end
    if (in_valid && active) begin
      prev_r <= best;
    end
    if (load_we && (load_idx == IDX_W'(COL_IDX))) begin
      sym_r <= load_sym;
    end
  end

endmodule

/* design/gasf_ctrl.sv */
// gasf_ctrl: score registers, column bookkeeping, row counter and the head of the cell row
// depends on gasf_pkg
module gasf_ctrl #(
  parameter int MAX_COLUMNS = gasf_pkg::DEF_MAX_COLUMNS,
  parameter int SCORE_BITS  = gasf_pkg::DEF_SCORE_BITS,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_action,
  input  logic [gasf_pkg::SYM_W-1:0]        in_symbol,
  input  logic                              in_is_last,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [gasf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gasf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              chain_done,
  output gasf_pkg::score_cfg_t              cfg_o,
  output logic [CNT_W-1:0]                  col_count,
  output logic                              load_we,
  output logic [IDX_W-1:0]                  load_idx,
  output logic [gasf_pkg::SYM_W-1:0]        load_sym,
  output logic                              head_valid_r,
  output gasf_pkg::tag_t                    head_tag_r,
  output logic signed [SCORE_BITS-1:0]      head_left_r,
  output logic signed [SCORE_BITS-1:0]      head_diag_r,
  output logic signed [SCORE_BITS-1:0]      head_top_r
);
  import gasf_pkg::*;

  localparam int PW   = ROW_W + 1 + CFG_DATA_W;
  localparam int EW   = (SCORE_BITS > PW) ? SCORE_BITS : PW;
  localparam int FL_W = $clog2(MAX_COLUMNS + 4);

  localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  function automatic logic signed [SCORE_BITS-1:0] sat_p(input logic signed [PW-1:0] p);
    logic signed [EW-1:0] p_e;
    logic signed [EW-1:0] hi_e;
    logic signed [EW-1:0] lo_e;
    p_e  = EW'(p);
    hi_e = EW'(SMAX);
    lo_e = EW'(SMIN);
    if (p_e > hi_e) begin
      return SMAX;
    end else if (p_e < lo_e) begin
      return SMIN;
    end else begin
      return p_e[SCORE_BITS-1:0];
    end
  endfunction

  score_cfg_t        cfg_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              load_closed_r;
  logic              load_closed_nxt;
  logic              rows_open_r;
  logic              rows_open_nxt;
  logic [ROW_W-1:0]  rc_r;
  logic [ROW_W-1:0]  rc_nxt;
  logic [FL_W-1:0]   inflight_r;
  logic [FL_W-1:0]   inflight_nxt;

  logic              accept;
  logic              row_req;
  logic              first_row;
  logic [CNT_W-1:0]  count_eff;
  logic              room;
  logic [ROW_W-1:0]  rc_old;
  logic signed [PW-1:0] prod_diag;
  logic signed [PW-1:0] prod_left;

  assign busy      = (inflight_r != '0) && (in_action == ACT_LOAD);
  assign accept    = start && !busy;
  assign row_req   = accept && (in_action == ACT_ROW);
  assign count_eff = load_closed_r ? '0 : count_r;
  assign room      = count_eff < CNT_W'(MAX_COLUMNS);
  assign first_row = !rows_open_r;
  assign rc_old    = first_row ? '0 : rc_r;

  assign load_we   = accept && (in_action == ACT_LOAD) && room;
  assign load_idx  = count_eff[IDX_W-1:0];
  assign load_sym  = in_symbol;
  assign col_count = count_r;
  assign cfg_o     = cfg_r;

  assign prod_diag = $signed({1'b0, rc_old}) * cfg_r.gap_score;
  assign prod_left = $signed({1'b0, rc_nxt}) * cfg_r.gap_score;

  always_comb begin
    count_nxt       = count_r;
    load_closed_nxt = load_closed_r;
    rows_open_nxt   = rows_open_r;
    rc_nxt          = rc_old;
    if (rc_old != ROW_LIMIT) begin
      rc_nxt = rc_old + 1'b1;
    end
    if (accept) begin
      unique case (in_action)
        ACT_LOAD: begin
          count_nxt       = room ? count_eff + 1'b1 : count_eff;
          load_closed_nxt = in_is_last;
          rows_open_nxt   = 1'b0;
        end
        ACT_ROW: begin
          load_closed_nxt = 1'b1;
          rows_open_nxt   = !in_is_last;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (row_req && !chain_done) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (!row_req && chain_done) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_score    <= RESET_MATCH;
      cfg_r.mismatch_score <= RESET_MISMATCH;
      cfg_r.gap_score      <= RESET_GAP;
      count_r              <= '0;
      load_closed_r        <= 1'b0;
      rows_open_r          <= 1'b0;
      rc_r                 <= '0;
      inflight_r           <= '0;
      head_valid_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH:    cfg_r.match_score    <= cfg_data;
          REG_MISMATCH: cfg_r.mismatch_score <= cfg_data;
          REG_GAP:      cfg_r.gap_score      <= cfg_data;
          default: begin
          end
        endcase
      end
      count_r       <= count_nxt;
      load_closed_r <= load_closed_nxt;
      rows_open_r   <= rows_open_nxt;
      inflight_r    <= inflight_nxt;
      head_valid_r  <= row_req;
      if (row_req) begin
        rc_r <= rc_nxt;
      end
    end
  end

  // row request enters the cell row with its left boundary values
  always_ff @(posedge clk) begin
    if (row_req) begin
      head_tag_r.first_row <= first_row;
      head_tag_r.sym       <= in_symbol;
      head_tag_r.row       <= rc_nxt;
      head_tag_r.is_final  <= in_is_last;
      head_diag_r          <= sat_p(prod_diag);
      head_left_r          <= sat_p(prod_left);
      head_top_r           <= SCORE_BITS'(cfg_r.gap_score);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COLUMNS))
    else $error("column count beyond capacity");

  a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    chain_done |-> (inflight_r != '0))
    else $error("row result with no request in flight");

  a_head_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> (inflight_r != '0))
    else $error("head request not counted");

  a_head_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> (head_tag_r.row != '0))
    else $error("row number zero entering the cell row");
`endif

endmodule

/* design/global_alignment_score_fill.sv */
// A row request's result strobe passes the head register, every cell's register and the output register.
// Throughput: one row request per cycle; each request walks the cell row one column a cycle.
// A load request completes with no result, but busy holds it off until every
// row request in flight has delivered its result. Results are strobed for one cycle only.
// Reset (synchronous, active low) restores the score registers to 5, -4, -5 and clears the
// column count, row counter and all valid flags; column symbols are not cleared.
module global_alignment_score_fill #(
  parameter int MAX_COLUMNS = gasf_pkg::DEF_MAX_COLUMNS,
  parameter int SCORE_BITS  = gasf_pkg::DEF_SCORE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_action,
  input  logic [gasf_pkg::SYM_W-1:0]            in_symbol,
  input  logic                                  in_is_last,
  output logic                                  out_valid,
  output logic signed [gasf_pkg::OUT_SCORE_W-1:0] out_row_score,
  output logic [gasf_pkg::ROW_W-1:0]            out_row_number,
  output logic                                  out_is_final,
  input  logic                                  cfg_we,
  input  logic [gasf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gasf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gasf_pkg::*;

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int OW    = (SCORE_BITS > OUT_SCORE_W) ? SCORE_BITS : OUT_SCORE_W;

  localparam logic signed [OUT_SCORE_W-1:0] OMAX = {1'b0, {(OUT_SCORE_W-1){1'b1}}};
  localparam logic signed [OUT_SCORE_W-1:0] OMIN = {1'b1, {(OUT_SCORE_W-1){1'b0}}};

  function automatic logic signed [OUT_SCORE_W-1:0] sat_out(
    input logic signed [SCORE_BITS-1:0] v
  );
    logic signed [OW-1:0] v_e;
    logic signed [OW-1:0] hi_e;
    logic signed [OW-1:0] lo_e;
    v_e  = OW'(v);
    hi_e = OW'(OMAX);
    lo_e = OW'(OMIN);
    if (v_e > hi_e) begin
      return OMAX;
    end else if (v_e < lo_e) begin
      return OMIN;
    end else begin
      return v_e[OUT_SCORE_W-1:0];
    end
  endfunction

  score_cfg_t                    cfg;
  logic [CNT_W-1:0]              col_count;
  logic                          load_we;
  logic [IDX_W-1:0]              load_idx;
  logic [SYM_W-1:0]              load_sym;

  logic                          chain_valid [0:MAX_COLUMNS];
  tag_t                          chain_tag   [0:MAX_COLUMNS];
  logic signed [SCORE_BITS-1:0]  chain_left  [0:MAX_COLUMNS];
  logic signed [SCORE_BITS-1:0]  chain_diag  [0:MAX_COLUMNS-1];
  logic signed [SCORE_BITS-1:0]  chain_top   [0:MAX_COLUMNS-1];

  logic                          out_valid_r;
  logic signed [OUT_SCORE_W-1:0] out_row_score_r;
  logic [ROW_W-1:0]              out_row_number_r;
  logic                          out_is_final_r;

  gasf_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SCORE_BITS  (SCORE_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_action    (in_action),
    .in_symbol    (in_symbol),
    .in_is_last   (in_is_last),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chain_done   (out_valid_r),
    .cfg_o        (cfg),
    .col_count    (col_count),
    .load_we      (load_we),
    .load_idx     (load_idx),
    .load_sym     (load_sym),
    .head_valid_r (chain_valid[0]),
    .head_tag_r   (chain_tag[0]),
    .head_left_r  (chain_left[0]),
    .head_diag_r  (chain_diag[0]),
    .head_top_r   (chain_top[0])
  );

  for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_cell
    if (j < MAX_COLUMNS - 1) begin : g_mid
      gasf_cell #(
        .SCORE_BITS (SCORE_BITS),
        .COL_IDX    (j),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .col_count   (col_count),
        .load_we     (load_we),
        .load_idx    (load_idx),
        .load_sym    (load_sym),
        .in_valid    (chain_valid[j]),
        .in_tag      (chain_tag[j]),
        .in_left     (chain_left[j]),
        .in_diag     (chain_diag[j]),
        .in_top      (chain_top[j]),
        .out_valid_r (chain_valid[j+1]),
        .out_tag_r   (chain_tag[j+1]),
        .out_left_r  (chain_left[j+1]),
        .out_diag_r  (chain_diag[j+1]),
        .out_top_r   (chain_top[j+1])
      );
    end else begin : g_end
      gasf_cell #(
        .SCORE_BITS (SCORE_BITS),
        .COL_IDX    (j),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .col_count   (col_count),
        .load_we     (load_we),
        .load_idx    (load_idx),
        .load_sym    (load_sym),
        .in_valid    (chain_valid[j]),
        .in_tag      (chain_tag[j]),
        .in_left     (chain_left[j]),
        .in_diag     (chain_diag[j]),
        .in_top      (chain_top[j]),
        .out_valid_r (chain_valid[j+1]),
        .out_tag_r   (chain_tag[j+1]),
        .out_left_r  (chain_left[j+1]),
        .out_diag_r  (),
        .out_top_r   ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_valid[MAX_COLUMNS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[MAX_COLUMNS]) begin
      out_row_score_r  <= sat_out(chain_left[MAX_COLUMNS]);
      out_row_number_r <= chain_tag[MAX_COLUMNS].row;
      out_is_final_r   <= chain_tag[MAX_COLUMNS].is_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_score  = out_row_score_r;
  assign out_row_number = out_row_number_r;
  assign out_is_final   = out_is_final_r;

endmodule
